[rtl/mvn_pkg.sv]
// mvn_pkg: shared widths, operation codes and result types of the mesh vertex
// normals unit. No dependencies.
package mvn_pkg;

   localparam int VERTEX_DEPTH = 256;
   localparam int ADDR_W       = $clog2(VERTEX_DEPTH);
   localparam int COORD_W      = 16;
   localparam int EDGE_W       = COORD_W + 1;
   localparam int PROD_W       = 2 * EDGE_W;
   localparam int VEC_W        = PROD_W + 1;
   localparam int ACC_W        = 24;
   localparam int NORM_W       = 16;
   localparam int FIT_W        = 24;
   localparam int SQ_W         = 2 * FIT_W + 2;
   localparam int ROOT_W       = FIT_W + 1;
   localparam int QUO_W        = 15;

   typedef enum logic [1:0] {
      OP_WRITE_VERTEX = 2'd0,
      OP_CLEAR        = 2'd1,
      OP_ADD_FACE     = 2'd2,
      OP_READ_NORMAL  = 2'd3
   } op_type;

   localparam logic KIND_FACE   = 1'b0;
   localparam logic KIND_VERTEX = 1'b1;

   typedef struct packed {
      logic signed [NORM_W-1:0] x;
      logic signed [NORM_W-1:0] y;
      logic signed [NORM_W-1:0] z;
      logic                     deg;
   } norm_res_type;

endpackage

[rtl/mvn_if.sv]
// mvn_req_if / mvn_rsp_if: valid-ready channels of the mesh vertex normals unit.
// Depends on mvn_pkg for field widths.
interface mvn_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          operation;
   logic [7:0]                          vertex_index;
   logic signed [mvn_pkg::COORD_W-1:0]  pos_x;
   logic signed [mvn_pkg::COORD_W-1:0]  pos_y;
   logic signed [mvn_pkg::COORD_W-1:0]  pos_z;
   logic [7:0]                          corner_a;
   logic [7:0]                          corner_b;
   logic [7:0]                          corner_c;
   modport source (output valid, operation, vertex_index, pos_x, pos_y, pos_z,
                   corner_a, corner_b, corner_c, input ready);
   modport sink (input valid, operation, vertex_index, pos_x, pos_y, pos_z,
                 corner_a, corner_b, corner_c, output ready);
endinterface

interface mvn_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               kind;
   logic signed [mvn_pkg::NORM_W-1:0]  norm_x;
   logic signed [mvn_pkg::NORM_W-1:0]  norm_y;
   logic signed [mvn_pkg::NORM_W-1:0]  norm_z;
   logic                               degenerate;
   modport source (output valid, kind, norm_x, norm_y, norm_z, degenerate, input ready);
   modport sink (input valid, kind, norm_x, norm_y, norm_z, degenerate, output ready);
endinterface

[rtl/mvn_norm.sv]
// mvn_norm: iterative vector normalizer: range fit, sum of squares, bit-pair
// square root and restoring divide per component. Depends on mvn_pkg.
module mvn_norm (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [mvn_pkg::VEC_W-1:0]   vec_x,
   input  logic signed [mvn_pkg::VEC_W-1:0]   vec_y,
   input  logic signed [mvn_pkg::VEC_W-1:0]   vec_z,
   output logic                               done,
   output mvn_pkg::norm_res_type              res
);

   typedef enum logic [6:0] {
      N_IDLE   = 7'b0000001,
      N_SHIFT  = 7'b0000010,
      N_SQUARE = 7'b0000100,
      N_SQRT   = 7'b0001000,
      N_DLOAD  = 7'b0010000,
      N_DSTEP  = 7'b0100000,
      N_DONE   = 7'b1000000
   } nstate_type;

   localparam int NUM_W = mvn_pkg::FIT_W + mvn_pkg::QUO_W + 1;
   localparam int REM_W = mvn_pkg::ROOT_W + 2;

   nstate_type                        state_ff, state_in;
   logic [mvn_pkg::VEC_W-1:0]         m_ff [3];
   logic [mvn_pkg::VEC_W-1:0]         m_in [3];
   logic [2:0]                        neg_ff, neg_in;
   logic [4:0]                        cnt_ff, cnt_in;
   logic [1:0]                        k_ff, k_in;
   logic [mvn_pkg::SQ_W-1:0]          len2_ff, len2_in;
   logic [mvn_pkg::ROOT_W-1:0]        root_ff, root_in;
   logic [REM_W-1:0]                  rem_ff, rem_in;
   logic [mvn_pkg::QUO_W-1:0]         dnum_ff, dnum_in;
   logic [mvn_pkg::QUO_W-1:0]         q_ff, q_in;
   mvn_pkg::norm_res_type             res_ff, res_in;

   logic signed [mvn_pkg::VEC_W-1:0]  vin [3];
   logic [mvn_pkg::VEC_W-1:0]         mx;
   logic [2*mvn_pkg::FIT_W-1:0]       sq;
   logic [REM_W-1:0]                  rem_s, trial, rd, dv;
   logic [NUM_W-1:0]                  num;
   logic [mvn_pkg::QUO_W-1:0]         q_next;
   logic signed [mvn_pkg::NORM_W-1:0] qv;

   assign vin[0] = vec_x;
   assign vin[1] = vec_y;
   assign vin[2] = vec_z;

   always_comb begin
      mx = m_ff[0];
      if (m_ff[1] > mx) begin
         mx = m_ff[1];
      end
      if (m_ff[2] > mx) begin
         mx = m_ff[2];
      end
      sq     = m_ff[k_ff][mvn_pkg::FIT_W-1:0] * m_ff[k_ff][mvn_pkg::FIT_W-1:0];
      rem_s  = {rem_ff[mvn_pkg::ROOT_W-1:0], len2_ff[mvn_pkg::SQ_W-1 -: 2]};
      trial  = {root_ff, 2'b01};
      num    = {1'b0, m_ff[k_ff][mvn_pkg::FIT_W-1:0], {mvn_pkg::QUO_W{1'b0}}}
               + NUM_W'(root_ff);
      rd     = {rem_ff[REM_W-2:0], dnum_ff[mvn_pkg::QUO_W-1]};
      dv     = {1'b0, root_ff, 1'b0};
      q_next = {q_ff[mvn_pkg::QUO_W-2:0], (rd >= dv)};
      qv     = mvn_pkg::NORM_W'(q_next);
      if (neg_ff[k_ff]) begin
         qv = -qv;
      end
   end

   always_comb begin
      state_in = state_ff;
      m_in     = m_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      k_in     = k_ff;
      len2_in  = len2_ff;
      root_in  = root_ff;
      rem_in   = rem_ff;
      dnum_in  = dnum_ff;
      q_in     = q_ff;
      res_in   = res_ff;
      case (state_ff)
         N_IDLE: begin
            if (start) begin
               for (int i = 0; i < 3; i++) begin
                  neg_in[i] = vin[i][mvn_pkg::VEC_W-1];
                  m_in[i]   = vin[i][mvn_pkg::VEC_W-1] ? mvn_pkg::VEC_W'(-vin[i])
                                                       : mvn_pkg::VEC_W'(vin[i]);
               end
               if (vin[0] == '0 && vin[1] == '0 && vin[2] == '0) begin
                  res_in   = '{x: '0, y: '0, z: '0, deg: 1'b1};
                  state_in = N_DONE;
               end else begin
                  state_in = N_SHIFT;
               end
            end
         end
         N_SHIFT: begin
            if (mx[mvn_pkg::VEC_W-1:mvn_pkg::FIT_W] != '0) begin
               for (int i = 0; i < 3; i++) begin
                  m_in[i] = m_ff[i] >> 1;
               end
            end else if (!mx[mvn_pkg::FIT_W-1]) begin
               for (int i = 0; i < 3; i++) begin
                  m_in[i] = m_ff[i] << 1;
               end
            end else begin
               len2_in  = '0;
               k_in     = '0;
               state_in = N_SQUARE;
            end
         end
         N_SQUARE: begin
            len2_in = len2_ff + mvn_pkg::SQ_W'(sq);
            if (k_ff == 2'd2) begin
               k_in     = '0;
               cnt_in   = '0;
               rem_in   = '0;
               root_in  = '0;
               state_in = N_SQRT;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         N_SQRT: begin
            len2_in = len2_ff << 2;
            if (rem_s >= trial) begin
               rem_in  = rem_s - trial;
               root_in = {root_ff[mvn_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_s;
               root_in = {root_ff[mvn_pkg::ROOT_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(mvn_pkg::ROOT_W - 1)) begin
               state_in = N_DLOAD;
            end
         end
         N_DLOAD: begin
            rem_in   = REM_W'(num[NUM_W-1:mvn_pkg::QUO_W]);
            dnum_in  = num[mvn_pkg::QUO_W-1:0];
            q_in     = '0;
            cnt_in   = '0;
            state_in = N_DSTEP;
         end
         N_DSTEP: begin
            rem_in  = (rd >= dv) ? rd - dv : rd;
            dnum_in = dnum_ff << 1;
            q_in    = q_next;
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == 5'(mvn_pkg::QUO_W - 1)) begin
               case (k_ff)
                  2'd0:    res_in.x = qv;
                  2'd1:    res_in.y = qv;
                  default: res_in.z = qv;
               endcase
               res_in.deg = 1'b0;
               if (k_ff == 2'd2) begin
                  state_in = N_DONE;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = N_DLOAD;
               end
            end
         end
         N_DONE: begin
            state_in = N_IDLE;
         end
         default: begin
            state_in = N_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
      end else begin
         state_ff <= state_in;
      end
      m_ff    <= m_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      k_ff    <= k_in;
      len2_ff <= len2_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
      dnum_ff <= dnum_in;
      q_ff    <= q_in;
      res_ff  <= res_in;
   end

   assign done = (state_ff == N_DONE);
   assign res  = res_ff;

endmodule

[rtl/mesh_vertex_normals_unit.sv]
// mesh_vertex_normals_unit: position and normal-sum memories, face and vertex
// sequencer around the mvn_norm normalizer. Depends on mvn_pkg, mvn_if, mvn_norm.
//
//  channel | dir | fields
//  req     | in  | operation, vertex_index, pos_x/y/z, corner_a/b/c
//  rsp     | out | kind, norm_x/y/z, degenerate
//
// write vertex and clear normals stay in idle; clear drops per-entry valid bits
// read normal: read sum, normalize, respond; add face: 3 fetches, 6 cross multiplies,
// normalize, 3 sum updates; the normalizer does a shift fit, 3 squares, a 25-step
// root and 3 x 15-step divide, and goes straight to done for a zero vector
// reset clears valid bits at once; no clearing pass
// one item at a time; a finished result waits in the rsp register for ready
module mesh_vertex_normals_unit (
   input  logic        clock,
   input  logic        reset,
   mvn_req_if.sink     req,
   mvn_rsp_if.source   rsp
);

   typedef enum logic [7:0] {
      T_IDLE  = 8'b00000001,
      T_FETCH = 8'b00000010,
      T_CROSS = 8'b00000100,
      T_RDS   = 8'b00001000,
      T_NGO   = 8'b00010000,
      T_NWAIT = 8'b00100000,
      T_ACC   = 8'b01000000,
      T_OUT   = 8'b10000000
   } tstate_type;

   localparam int CW   = mvn_pkg::COORD_W;
   localparam int AW   = mvn_pkg::ACC_W;
   localparam int AD   = mvn_pkg::ADDR_W;

   tstate_type                         state_ff, state_in;
   logic [2:0]                         cnt_ff, cnt_in;
   logic                               phase_ff, phase_in;
   logic                               is_face_ff, is_face_in;
   logic [AD-1:0]                      corner_ff [3];
   logic [AD-1:0]                      corner_in [3];
   logic [3*CW-1:0]                    pa_ff, pa_in, pb_ff, pb_in;
   logic signed [mvn_pkg::EDGE_W-1:0]  e1_ff [3];
   logic signed [mvn_pkg::EDGE_W-1:0]  e1_in [3];
   logic signed [mvn_pkg::EDGE_W-1:0]  e2_ff [3];
   logic signed [mvn_pkg::EDGE_W-1:0]  e2_in [3];
   logic signed [mvn_pkg::VEC_W-1:0]   vec_ff [3];
   logic signed [mvn_pkg::VEC_W-1:0]   vec_in [3];
   logic [mvn_pkg::VERTEX_DEPTH-1:0]   valid_ff, valid_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_kind_ff, rsp_kind_in;
   mvn_pkg::norm_res_type              rsp_res_ff, rsp_res_in;

   logic [3*CW-1:0]                    pos_mem [mvn_pkg::VERTEX_DEPTH];
   logic [3*CW-1:0]                    pos_rd_ff;
   logic [3*AW-1:0]                    sum_mem [mvn_pkg::VERTEX_DEPTH];
   logic [3*AW-1:0]                    sum_rd_ff;
   logic                               sum_vld_ff;

   logic                               accept;
   logic                               pos_we, sum_we;
   logic [AD-1:0]                      pos_raddr, sum_raddr, pos_waddr;
   logic [3*CW-1:0]                    pos_wdata;
   logic [3*AW-1:0]                    sum_wdata;
   logic                               norm_start, norm_done;
   mvn_pkg::norm_res_type              nres;
   logic signed [mvn_pkg::EDGE_W-1:0]  mul_a, mul_b;
   logic signed [mvn_pkg::PROD_W-1:0]  prod;
   logic signed [AW-1:0]               cur [3];
   logic signed [mvn_pkg::NORM_W-1:0]  nv [3];
   logic signed [AW:0]                 s [3];
   logic [1:0]                         dst;
   logic [1:0]                         k;

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == T_IDLE);
   assign k         = cnt_ff[1:0];
   assign dst       = cnt_ff[2:1];
   assign pos_waddr = req.vertex_index[AD-1:0];
   assign pos_wdata = {req.pos_z, req.pos_y, req.pos_x};
   assign pos_raddr = (state_ff == T_FETCH) ? ((cnt_ff == 3'd0) ? corner_ff[1] : corner_ff[2])
                                            : req.corner_a[AD-1:0];
   assign sum_raddr = (state_ff == T_ACC) ? corner_ff[k] : req.vertex_index[AD-1:0];
   assign nv[0]     = nres.x;
   assign nv[1]     = nres.y;
   assign nv[2]     = nres.z;

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[pos_waddr] <= pos_wdata;
      end
      pos_rd_ff <= pos_mem[pos_raddr];
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[corner_ff[k]] <= sum_wdata;
      end
      sum_rd_ff  <= sum_mem[sum_raddr];
      sum_vld_ff <= valid_ff[sum_raddr];
   end

   mvn_norm u_norm (
      .clock (clock),
      .reset (reset),
      .start (norm_start),
      .vec_x (vec_ff[0]),
      .vec_y (vec_ff[1]),
      .vec_z (vec_ff[2]),
      .done  (norm_done),
      .res   (nres)
   );

   // cross product, one multiply per cycle
   always_comb begin
      case (cnt_ff)
         3'd0:    begin mul_a = e1_ff[1]; mul_b = e2_ff[2]; end
         3'd1:    begin mul_a = e1_ff[2]; mul_b = e2_ff[1]; end
         3'd2:    begin mul_a = e1_ff[2]; mul_b = e2_ff[0]; end
         3'd3:    begin mul_a = e1_ff[0]; mul_b = e2_ff[2]; end
         3'd4:    begin mul_a = e1_ff[0]; mul_b = e2_ff[1]; end
         default: begin mul_a = e1_ff[1]; mul_b = e2_ff[0]; end
      endcase
      prod = mul_a * mul_b;
   end

   // saturating accumulate
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cur[i] = sum_vld_ff ? $signed(sum_rd_ff[i*AW +: AW]) : '0;
         s[i]   = (AW+1)'(cur[i]) + (AW+1)'(nv[i]);
         if (s[i][AW] != s[i][AW-1]) begin
            sum_wdata[i*AW +: AW] = s[i][AW] ? {1'b1, {(AW-1){1'b0}}}
                                             : {1'b0, {(AW-1){1'b1}}};
         end else begin
            sum_wdata[i*AW +: AW] = s[i][AW-1:0];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      phase_in     = phase_ff;
      is_face_in   = is_face_ff;
      corner_in    = corner_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      e1_in        = e1_ff;
      e2_in        = e2_ff;
      vec_in       = vec_ff;
      valid_in     = valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_res_in   = rsp_res_ff;
      rsp_valid_in = rsp.ready ? 1'b0 : rsp_valid_ff;
      pos_we       = 1'b0;
      sum_we       = 1'b0;
      norm_start   = 1'b0;
      case (state_ff)
         T_IDLE: begin
            if (accept) begin
               case (mvn_pkg::op_type'(req.operation))
                  mvn_pkg::OP_WRITE_VERTEX: pos_we = 1'b1;
                  mvn_pkg::OP_CLEAR:        valid_in = '0;
                  mvn_pkg::OP_ADD_FACE: begin
                     corner_in[0] = req.corner_a[AD-1:0];
                     corner_in[1] = req.corner_b[AD-1:0];
                     corner_in[2] = req.corner_c[AD-1:0];
                     is_face_in   = 1'b1;
                     cnt_in       = '0;
                     state_in     = T_FETCH;
                  end
                  default: begin
                     is_face_in = 1'b0;
                     state_in   = T_RDS;
                  end
               endcase
            end
         end
         T_FETCH: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd0) begin
               pa_in = pos_rd_ff;
            end else if (cnt_ff == 3'd1) begin
               pb_in = pos_rd_ff;
            end else begin
               for (int i = 0; i < 3; i++) begin
                  e1_in[i] = mvn_pkg::EDGE_W'($signed(pb_ff[i*CW +: CW]))
                           - mvn_pkg::EDGE_W'($signed(pa_ff[i*CW +: CW]));
                  e2_in[i] = mvn_pkg::EDGE_W'($signed(pos_rd_ff[i*CW +: CW]))
                           - mvn_pkg::EDGE_W'($signed(pa_ff[i*CW +: CW]));
               end
               cnt_in   = '0;
               state_in = T_CROSS;
            end
         end
         T_CROSS: begin
            vec_in[dst] = cnt_ff[0] ? vec_ff[dst] - mvn_pkg::VEC_W'(prod)
                                    : mvn_pkg::VEC_W'(prod);
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd5) begin
               state_in = T_NGO;
            end
         end
         T_RDS: begin
            for (int i = 0; i < 3; i++) begin
               vec_in[i] = sum_vld_ff ? mvn_pkg::VEC_W'($signed(sum_rd_ff[i*AW +: AW])) : '0;
            end
            state_in = T_NGO;
         end
         T_NGO: begin
            norm_start = 1'b1;
            state_in   = T_NWAIT;
         end
         T_NWAIT: begin
            if (norm_done) begin
               cnt_in   = '0;
               phase_in = 1'b0;
               state_in = is_face_ff ? T_ACC : T_OUT;
            end
         end
         T_ACC: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               sum_we                = 1'b1;
               valid_in[corner_ff[k]] = 1'b1;
               cnt_in                = cnt_ff + 3'd1;
               if (k == 2'd2) begin
                  state_in = T_OUT;
               end
            end
         end
         T_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = is_face_ff ? mvn_pkg::KIND_FACE : mvn_pkg::KIND_VERTEX;
               rsp_res_in   = nres;
               state_in     = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
      end
      is_face_ff  <= is_face_in;
      corner_ff   <= corner_in;
      pa_ff       <= pa_in;
      pb_ff       <= pb_in;
      e1_ff       <= e1_in;
      e2_ff       <= e2_in;
      vec_ff      <= vec_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_res_ff  <= rsp_res_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.kind       = rsp_kind_ff;
   assign rsp.norm_x     = rsp_res_ff.x;
   assign rsp.norm_y     = rsp_res_ff.y;
   assign rsp.norm_z     = rsp_res_ff.z;
   assign rsp.degenerate = rsp_res_ff.deg;

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      norm_done |-> state_ff == T_NWAIT) else $error("normalizer done outside wait");
   a_sum_write: assert property (@(posedge clock) disable iff (reset)
      sum_we |-> (state_ff == T_ACC && phase_ff)) else $error("sum write outside update");
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == T_OUT)) else $error("result from wrong state");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && req.operation == mvn_pkg::OP_CLEAR) |=> valid_ff == '0)
      else $error("clear left valid entries");

endmodule
